// ===== src/ftr_pkg.sv =====
// ----------------------------------------------------------------------------
// ftr_pkg
// Shared types, constants and helpers for the transpose/rotate frame buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package ftr_pkg;

   localparam int MAX_DIM    = 64;
   localparam int PIXEL_BITS = 32;

   localparam int DIM_BITS   = $clog2(MAX_DIM);
   localparam int CNT_BITS   = DIM_BITS + 1;
   localparam int ADDR_BITS  = 2 * DIM_BITS;
   localparam int STORE_DEPTH = 1 << ADDR_BITS;

   localparam int MODE_W  = 2;
   localparam int DIM_W   = 7;
   localparam int BYTES_W = 3;
   localparam int CSR_DATA_W  = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int WORD_W  = 32;

   localparam logic [WORD_W-1:0] PIXEL_MASK =
      (PIXEL_BITS >= WORD_W) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << PIXEL_BITS) - 64'd1);

   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_READ = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROTATE_MODE  = 2'd0,
      CSR_FRAME_WIDTH  = 2'd1,
      CSR_FRAME_HEIGHT = 2'd2,
      CSR_PIXEL_BYTES  = 2'd3
   } csr_index_type;

   function automatic logic [CNT_BITS-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [CNT_BITS-1:0] r;
      if (v == '0) begin
         r = CNT_BITS'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = CNT_BITS'(MAX_DIM);
      end else begin
         r = CNT_BITS'(v);
      end
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] byte_mask(input logic [BYTES_W-1:0] nb);
      logic [WORD_W-1:0] m;
      unique case (nb)
         3'd0, 3'd1: begin
            m = 32'h0000_00FF;
         end
         3'd2: begin
            m = 32'h0000_FFFF;
         end
         3'd3: begin
            m = 32'h00FF_FFFF;
         end
         default: begin
            m = 32'hFFFF_FFFF;
         end
      endcase
      return m & PIXEL_MASK;
   endfunction

endpackage

`default_nettype wire

// ===== src/ftr_ram.sv =====
// ----------------------------------------------------------------------------
// ftr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ftr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/frame_transpose_rotate.sv =====
// ----------------------------------------------------------------------------
// frame_transpose_rotate
// Frame buffer: loads a frame in raster order, plays it back transposed,
// optionally with source rows and/or columns reversed (quarter turns).
//
//  channel  | ports                                        | direction
//  ---------+----------------------------------------------+----------
//  request  | start, busy (out), req_type, req_pixel_in    | in
//  response | rsp_strobe, rsp_pixel_out, rsp_frame_end,    | out
//           | rsp_no_data                                  |
//  config   | csr_write_enable, csr_index, csr_data        | in
//
// One transaction per cycle; busy stays low. A load writes the store in the
// cycle it is taken; a read addresses the store's read port in the cycle it
// is taken and its response appears in the next cycle, since the frame store
// has a registered read. Reset clears positions and the ready flag; store
// contents are not cleared. The receiver cannot stall responses.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_transpose_rotate (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_type,
   input  wire logic [ftr_pkg::WORD_W-1:0]     req_pixel_in,
   output logic                                rsp_strobe,
   output logic      [ftr_pkg::WORD_W-1:0]     rsp_pixel_out,
   output logic                                rsp_frame_end,
   output logic                                rsp_no_data,
   input  wire logic                           csr_write_enable,
   input  wire logic [ftr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ftr_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int DB = ftr_pkg::DIM_BITS;
   localparam int CB = ftr_pkg::CNT_BITS;

   logic [ftr_pkg::MODE_W-1:0]  mode_ff;
   logic [ftr_pkg::DIM_W-1:0]   width_ff, height_ff;
   logic [ftr_pkg::BYTES_W-1:0] bytes_ff;

   logic [DB-1:0] load_row_ff, load_row_in, load_col_ff, load_col_in;
   logic [DB-1:0] emit_row_ff, emit_row_in, emit_col_ff, emit_col_in;
   logic          frame_ready_ff, frame_ready_in;

   logic                        strobe_ff, strobe_in;
   logic                        no_data_ff, no_data_in;
   logic                        end_ff, end_in;
   logic [ftr_pkg::WORD_W-1:0]  mask_ff, mask_in;

   logic [CB-1:0] w, h;
   logic [DB-1:0] lr, lc, er, ec;
   logic [CB-1:0] src_row, src_col;
   logic          accept;

   logic                           wr_en, rd_en;
   logic [ftr_pkg::ADDR_BITS-1:0]  wr_addr, rd_addr;
   logic [ftr_pkg::WORD_W-1:0]     rd_data;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign w      = ftr_pkg::clamp_dim(width_ff);
   assign h      = ftr_pkg::clamp_dim(height_ff);

   always_comb begin
      load_row_in    = load_row_ff;
      load_col_in    = load_col_ff;
      emit_row_in    = emit_row_ff;
      emit_col_in    = emit_col_ff;
      frame_ready_in = frame_ready_ff;
      strobe_in      = 1'b0;
      no_data_in     = 1'b0;
      end_in         = 1'b0;
      mask_in        = '0;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      lr             = load_row_ff;
      lc             = load_col_ff;
      er             = emit_row_ff;
      ec             = emit_col_ff;
      src_row        = CB'(ec);
      src_col        = CB'(er);
      wr_addr        = {lr, lc};
      rd_addr        = {src_row[DB-1:0], src_col[DB-1:0]};
      if (accept) begin
         if (req_type == ftr_pkg::REQ_LOAD) begin
            if (frame_ready_ff) begin
               lr             = '0;
               lc             = '0;
               emit_row_in    = '0;
               emit_col_in    = '0;
               frame_ready_in = 1'b0;
            end
            if (CB'(lr) >= h || CB'(lc) >= w) begin
               lr = '0;
               lc = '0;
            end
            wr_en   = 1'b1;
            wr_addr = {lr, lc};
            if (CB'(lc) + CB'(1) >= w) begin
               load_col_in = '0;
               if (CB'(lr) + CB'(1) >= h) begin
                  load_row_in    = '0;
                  frame_ready_in = 1'b1;
                  emit_row_in    = '0;
                  emit_col_in    = '0;
               end else begin
                  load_row_in = lr + DB'(1);
               end
            end else begin
               load_row_in = lr;
               load_col_in = lc + DB'(1);
            end
         end else begin
            strobe_in = 1'b1;
            if (!frame_ready_ff) begin
               no_data_in = 1'b1;
            end else begin
               if (CB'(er) >= w || CB'(ec) >= h) begin
                  er = '0;
                  ec = '0;
               end
               src_row = mode_ff[0] ? (h - CB'(1) - CB'(ec)) : CB'(ec);
               src_col = mode_ff[1] ? (w - CB'(1) - CB'(er)) : CB'(er);
               rd_en   = 1'b1;
               rd_addr = {src_row[DB-1:0], src_col[DB-1:0]};
               mask_in = ftr_pkg::byte_mask(bytes_ff);
               if (CB'(ec) + CB'(1) >= h) begin
                  emit_col_in = '0;
                  if (CB'(er) + CB'(1) >= w) begin
                     emit_row_in = '0;
                     end_in      = 1'b1;
                  end else begin
                     emit_row_in = er + DB'(1);
                  end
               end else begin
                  emit_row_in = er;
                  emit_col_in = ec + DB'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= '0;
         width_ff       <= ftr_pkg::DIM_W'(ftr_pkg::MAX_DIM);
         height_ff      <= ftr_pkg::DIM_W'(ftr_pkg::MAX_DIM);
         bytes_ff       <= ftr_pkg::BYTES_W'(4);
         load_row_ff    <= '0;
         load_col_ff    <= '0;
         emit_row_ff    <= '0;
         emit_col_ff    <= '0;
         frame_ready_ff <= 1'b0;
         strobe_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               ftr_pkg::CSR_ROTATE_MODE: begin
                  mode_ff <= csr_data[ftr_pkg::MODE_W-1:0];
               end
               ftr_pkg::CSR_FRAME_WIDTH: begin
                  width_ff <= csr_data[ftr_pkg::DIM_W-1:0];
               end
               ftr_pkg::CSR_FRAME_HEIGHT: begin
                  height_ff <= csr_data[ftr_pkg::DIM_W-1:0];
               end
               ftr_pkg::CSR_PIXEL_BYTES: begin
                  bytes_ff <= csr_data[ftr_pkg::BYTES_W-1:0];
               end
               default: begin
               end
            endcase
         end
         load_row_ff    <= load_row_in;
         load_col_ff    <= load_col_in;
         emit_row_ff    <= emit_row_in;
         emit_col_ff    <= emit_col_in;
         frame_ready_ff <= frame_ready_in;
         strobe_ff      <= strobe_in;
      end
      no_data_ff <= no_data_in;
      end_ff     <= end_in;
      mask_ff    <= mask_in;
   end

   ftr_ram #(
      .WIDTH (ftr_pkg::WORD_W),
      .DEPTH (ftr_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_pixel_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_strobe    = strobe_ff;
   assign rsp_pixel_out = rd_data & mask_ff;
   assign rsp_frame_end = end_ff;
   assign rsp_no_data   = no_data_ff;

   // a response only follows an accepted read transaction
   a_rsp_after_read: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept && req_type == ftr_pkg::REQ_READ))
      else $error("response without read transaction");

   a_no_data_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_no_data) |-> (rsp_pixel_out == '0 && !rsp_frame_end))
      else $error("no_data response carries payload");

   a_ready_load_pos: assert property (@(posedge clock) disable iff (reset)
      frame_ready_ff |-> (load_row_ff == '0 && load_col_ff == '0))
      else $error("load position moved while frame ready");

   a_end_wraps: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_frame_end) |-> (emit_row_ff == '0 && emit_col_ff == '0))
      else $error("read position did not wrap at frame end");

endmodule

`default_nettype wire

// ===== verif/transpose_check.sv =====
// ----------------------------------------------------------------------------
// transpose_check
// Watches the request, response and register ports of the transpose/rotate
// frame buffer. It keeps its own frame store, load and playback positions
// and register copies, predicts the response of every accepted read and
// compares it field by field with the strobed response, oldest first.
// ----------------------------------------------------------------------------
module transpose_check
   import ftr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  logic                   req_type,
   input  logic [WORD_W-1:0]      req_pixel_in,
   input  logic                   rsp_strobe,
   input  logic [WORD_W-1:0]      rsp_pixel_out,
   input  logic                   rsp_frame_end,
   input  logic                   rsp_no_data,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     mismatch_count,
   output int                     pending_reads,
   output int                     responses_checked
);

   typedef struct packed {
      logic [WORD_W-1:0] pixel;
      logic              last;
      logic              empty;
   } rotated_pixel_type;

   logic [WORD_W-1:0] frame_mem [MAX_DIM*MAX_DIM];
   rotated_pixel_type rotated_due [$];

   int unsigned       load_r, load_c, out_r, out_c;
   bit                have_frame;
   logic [MODE_W-1:0]  mode_q;
   logic [DIM_W-1:0]   width_q, height_q;
   logic [BYTES_W-1:0] bytes_q;

   initial begin
      mismatch_count = 0;
      pending_reads = 0;
      responses_checked = 0;
   end

   function automatic int unsigned dim_limit(input logic [DIM_W-1:0] v);
      if (v == '0) begin
         return 1;
      end
      if (int'(v) > MAX_DIM) begin
         return MAX_DIM;
      end
      return 32'(v);
   endfunction

   function automatic logic [WORD_W-1:0] keep_mask(input logic [BYTES_W-1:0] nb);
      logic [WORD_W-1:0] m;
      case (nb)
         3'd0, 3'd1: begin
            m = 32'h0000_00FF;
         end
         3'd2: begin
            m = 32'h0000_FFFF;
         end
         3'd3: begin
            m = 32'h00FF_FFFF;
         end
         default: begin
            m = 32'hFFFF_FFFF;
         end
      endcase
      return m & PIXEL_MASK;
   endfunction

   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                  input logic [WORD_W-1:0] got);
      if (mismatch_count < 40) begin
         $display("mismatch at %0t: %s expected %h, got %h", $realtime, what, want, got);
      end
      mismatch_count++;
   endtask

   // one accepted transaction: loads fill the store, reads queue a response
   task automatic take_request(input req_kind_type kind, input logic [WORD_W-1:0] pixel);
      int unsigned       w, h, src_r, src_c;
      rotated_pixel_type due;
      w = dim_limit(width_q);
      h = dim_limit(height_q);
      if (kind == REQ_LOAD) begin
         if (have_frame) begin
            have_frame = 1'b0;
            load_r = 0;
            load_c = 0;
            out_r = 0;
            out_c = 0;
         end
         if (load_r >= h || load_c >= w) begin
            load_r = 0;
            load_c = 0;
         end
         frame_mem[ADDR_BITS'(load_r * MAX_DIM + load_c)] = pixel;
         if (load_c + 1 >= w) begin
            load_c = 0;
            if (load_r + 1 >= h) begin
               load_r = 0;
               have_frame = 1'b1;
               out_r = 0;
               out_c = 0;
            end else begin
               load_r++;
            end
         end else begin
            load_c++;
         end
      end else if (!have_frame) begin
         due.pixel = '0;
         due.last = 1'b0;
         due.empty = 1'b1;
         rotated_due.push_back(due);
      end else begin
         if (out_r >= w || out_c >= h) begin
            out_r = 0;
            out_c = 0;
         end
         src_r = mode_q[0] ? h - 1 - out_c : out_c;
         src_c = mode_q[1] ? w - 1 - out_r : out_r;
         due.pixel = frame_mem[ADDR_BITS'(src_r * MAX_DIM + src_c)] & keep_mask(bytes_q);
         due.last = 1'b0;
         due.empty = 1'b0;
         if (out_c + 1 >= h) begin
            out_c = 0;
            if (out_r + 1 >= w) begin
               out_r = 0;
               due.last = 1'b1;
            end else begin
               out_r++;
            end
         end else begin
            out_c++;
         end
         rotated_due.push_back(due);
      end
   endtask

   task automatic check_response();
      rotated_pixel_type want;
      if (rotated_due.size() == 0) begin
         report_mismatch("response with no read pending, pixel_out", '0, rsp_pixel_out);
      end else begin
         want = rotated_due.pop_front();
         responses_checked++;
         if (rsp_pixel_out !== want.pixel) begin
            report_mismatch("pixel_out", want.pixel, rsp_pixel_out);
         end
         if (rsp_frame_end !== want.last) begin
            report_mismatch("frame_end", WORD_W'(want.last), WORD_W'(rsp_frame_end));
         end
         if (rsp_no_data !== want.empty) begin
            report_mismatch("no_data", WORD_W'(want.empty), WORD_W'(rsp_no_data));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rotated_due.delete();
         load_r = 0;
         load_c = 0;
         out_r = 0;
         out_c = 0;
         have_frame = 1'b0;
         mode_q = '0;
         width_q = DIM_W'(MAX_DIM);
         height_q = DIM_W'(MAX_DIM);
         bytes_q = BYTES_W'(4);
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_ROTATE_MODE: begin
                  mode_q = csr_data[MODE_W-1:0];
               end
               CSR_FRAME_WIDTH: begin
                  width_q = csr_data[DIM_W-1:0];
               end
               CSR_FRAME_HEIGHT: begin
                  height_q = csr_data[DIM_W-1:0];
               end
               CSR_PIXEL_BYTES: begin
                  bytes_q = csr_data[BYTES_W-1:0];
               end
               default: begin
               end
            endcase
         end
         // request first, so a response in the same cycle still finds its entry
         if (start && !busy) begin
            take_request(req_kind_type'(req_type), req_pixel_in);
         end
         if (rsp_strobe) begin
            check_response();
         end
      end
      pending_reads = rotated_due.size();
   end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the transpose/rotate frame buffer with a short directed sequence and
// then random phases: each phase sets mode, pixel size and frame geometry,
// loads a frame with random pixels and plays it back, with stray reads, frame
// restarts, mid-frame shrinking and random gaps. The checker module predicts
// and compares; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import ftr_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic                   req_type;
   logic [WORD_W-1:0]      req_pixel_in;
   logic                   rsp_strobe;
   logic [WORD_W-1:0]      rsp_pixel_out;
   logic                   rsp_frame_end;
   logic                   rsp_no_data;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   int mismatch_count;
   int pending_reads;
   int responses_checked;

   // where the next load lands, as the stimulus sees it
   int cur_w, cur_h, fill_row, fill_col;
   bit frame_full;
   bit steady;
   int load_count, read_count, phase_count;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   frame_transpose_rotate DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_pixel_in     (req_pixel_in),
      .rsp_strobe       (rsp_strobe),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_no_data      (rsp_no_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   transpose_check rotation_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_pixel_in      (req_pixel_in),
      .rsp_strobe        (rsp_strobe),
      .rsp_pixel_out     (rsp_pixel_out),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_no_data       (rsp_no_data),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .mismatch_count    (mismatch_count),
      .pending_reads     (pending_reads),
      .responses_checked (responses_checked)
   );

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      if (roll < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic int dim_of(input logic [DIM_W-1:0] v);
      if (v == '0) begin
         return 1;
      end
      if (int'(v) > MAX_DIM) begin
         return MAX_DIM;
      end
      return int'(v);
   endfunction

   task automatic rest(input int cycles);
      if (cycles > 0) begin
         start = 1'b0;
         req_pixel_in = $urandom;
      end
      repeat (cycles) @(negedge clock);
   endtask

   task automatic issue(input req_kind_type kind, input logic [WORD_W-1:0] pixel);
      start = 1'b1;
      req_type = kind;
      req_pixel_in = pixel;
      while (busy) @(negedge clock);
      @(negedge clock);
      if (!steady) begin
         rest(pick_gap());
      end
   endtask

   task automatic send_load(input logic [WORD_W-1:0] pixel);
      if (frame_full) begin
         frame_full = 1'b0;
         fill_row = 0;
         fill_col = 0;
      end
      if (fill_row >= cur_h || fill_col >= cur_w) begin
         fill_row = 0;
         fill_col = 0;
      end
      if (fill_col + 1 >= cur_w) begin
         fill_col = 0;
         if (fill_row + 1 >= cur_h) begin
            fill_row = 0;
            frame_full = 1'b1;
         end else begin
            fill_row++;
         end
      end else begin
         fill_col++;
      end
      load_count++;
      issue(REQ_LOAD, pixel);
   endtask

   task automatic send_read();
      read_count++;
      issue(REQ_READ, $urandom);
   endtask

   // hold off until every read has been answered
   task automatic settle();
      start = 1'b0;
      while (pending_reads != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      start = 1'b0;
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      csr_data = CSR_DATA_W'($urandom);
   endtask

   // Growing the frame is only safe from a frame boundary; a finished frame
   // must then be restarted by a load before any read.
   task automatic set_geometry(input logic [DIM_W-1:0] w_raw, input logic [DIM_W-1:0] h_raw,
                               output bit grew);
      int new_w, new_h;
      new_w = dim_of(w_raw);
      new_h = dim_of(h_raw);
      grew = (new_w > cur_w) || (new_h > cur_h);
      if (grew) begin
         while (!frame_full && (fill_row != 0 || fill_col != 0)) send_load($urandom);
      end
      settle();
      write_reg(CSR_FRAME_WIDTH, CSR_DATA_W'(w_raw));
      write_reg(CSR_FRAME_HEIGHT, CSR_DATA_W'(h_raw));
      cur_w = new_w;
      cur_h = new_h;
   endtask

   task automatic run_phase(input int p);
      logic [CSR_DATA_W-1:0] mode_raw, bytes_raw;
      logic [DIM_W-1:0]      w_raw, h_raw;
      bit                    grew;
      int                    cut, loaded, reads;
      settle();
      steady = ($urandom_range(0, 3) == 0);
      mode_raw = CSR_DATA_W'($urandom);
      bytes_raw = CSR_DATA_W'($urandom);
      if (p < 8) begin
         mode_raw[1:0] = p[1:0];
         bytes_raw[2:0] = p[2:0];
      end
      write_reg(CSR_ROTATE_MODE, mode_raw);
      write_reg(CSR_PIXEL_BYTES, bytes_raw);
      case (p)
         1: begin
            w_raw = 7'd127;
            h_raw = 7'd0;
         end
         3: begin
            w_raw = 7'd0;
            h_raw = 7'd127;
         end
         5: begin
            w_raw = 7'd64;
            h_raw = 7'd1;
         end
         7: begin
            w_raw = 7'd1;
            h_raw = 7'd64;
         end
         default: begin
            if ($urandom_range(0, 6) == 0) begin
               w_raw = DIM_W'($urandom_range(0, 12));
               h_raw = DIM_W'($urandom_range(0, 12));
            end else begin
               w_raw = DIM_W'($urandom_range(1, 6));
               h_raw = DIM_W'($urandom_range(1, 6));
            end
         end
      endcase
      set_geometry(w_raw, h_raw, grew);

      // a kept frame under a smaller size is still readable
      if (frame_full && !grew) begin
         repeat ($urandom_range(0, 3)) send_read();
      end

      cut = 0;
      if (cur_w * cur_h > 1 && $urandom_range(0, 3) == 0) begin
         cut = $urandom_range(1, cur_w * cur_h - 1);
      end
      send_load($urandom);
      loaded = 1;
      while (!frame_full) begin
         if ($urandom_range(0, 9) == 0) begin
            send_read();
         end
         if (loaded == cut) begin
            settle();
            set_geometry(DIM_W'($urandom_range(1, cur_w)), DIM_W'($urandom_range(1, cur_h)),
                         grew);
         end
         send_load($urandom);
         loaded++;
      end

      reads = cur_w * cur_h;
      if ($urandom_range(0, 2) == 0) begin
         reads += $urandom_range(1, cur_w * cur_h);
      end
      repeat (reads) begin
         if ($urandom_range(0, 39) == 0) begin
            send_load($urandom);
         end else begin
            send_read();
         end
      end
      phase_count++;
   endtask

   initial begin
      bit grew;
      reset = 1'b1;
      start = 1'b0;
      req_type = REQ_LOAD;
      req_pixel_in = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_ROTATE_MODE;
      csr_data = '0;
      cur_w = MAX_DIM;
      cur_h = MAX_DIM;
      fill_row = 0;
      fill_col = 0;
      frame_full = 1'b0;
      steady = 1'b0;
      load_count = 0;
      read_count = 0;
      phase_count = 0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // nothing loaded yet
      send_read();
      send_read();
      settle();
      write_reg(CSR_ROTATE_MODE, CSR_DATA_W'(0));
      write_reg(CSR_PIXEL_BYTES, CSR_DATA_W'(4));
      set_geometry(7'd1, 7'd1, grew);
      send_load(32'hFFFF_FFFF);
      send_read();
      send_read();
      send_load(32'h0000_0000);
      send_read();
      set_geometry(7'd3, 7'd2, grew);
      send_load(32'hAAAA_AAAA);
      send_load(32'h5555_5555);
      send_load(32'h0123_4567);
      send_read();
      send_load(32'h89AB_CDEF);
      send_load(32'hFFFF_0000);
      send_load(32'h0000_FFFF);
      settle();
      write_reg(CSR_ROTATE_MODE, CSR_DATA_W'(3));
      repeat (6) send_read();

      for (int p = 0; p < 10 || load_count + read_count < 500; p++) begin
         run_phase(p);
      end

      start = 1'b0;
      while (pending_reads != 0) @(negedge clock);
      repeat (4) @(negedge clock);

      $display("Covered %0d phases: %0d loads, %0d reads, %0d responses checked.",
               phase_count, load_count, read_count, responses_checked);
      $display("All rotate modes, pixel sizes 0-7, sizes 1-64 incl. 0 and 127, resizing.");
      if (mismatch_count == 0 && pending_reads == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
